@@ design/dwc_pkg.sv @@
// shared types, register map, operation codes and reset values for the window controller
package dwc_pkg;

  localparam int ACK_W     = 48;
  localparam int SEQ_OUT_W = 48;
  localparam int WIN_W     = 56;
  localparam int CNT_W     = 32;
  localparam int PROD_W    = 24;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ACK_W-1:0] ack_number;
    logic             ecn_marked;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_OUT_W-1:0] send_seqno;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] segment_size;
    logic [16:0] ewma_gain;
    logic [16:0] loss_shrink;
    logic [15:0] growth_factor;
    logic [7:0]  floor_segments;
    logic [7:0]  initial_segments;
  } cfg_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_NACK  = 2'd2;

  localparam logic [2:0] REG_SEGMENT_SIZE     = 3'd0;
  localparam logic [2:0] REG_EWMA_GAIN        = 3'd1;
  localparam logic [2:0] REG_LOSS_SHRINK      = 3'd2;
  localparam logic [2:0] REG_GROWTH_FACTOR    = 3'd3;
  localparam logic [2:0] REG_FLOOR_SEGMENTS   = 3'd4;
  localparam logic [2:0] REG_INITIAL_SEGMENTS = 3'd5;

  localparam logic [15:0] RST_SEGMENT_SIZE     = 16'd1500;
  localparam logic [16:0] RST_EWMA_GAIN        = 17'd4096;
  localparam logic [16:0] RST_LOSS_SHRINK      = 17'd197;
  localparam logic [15:0] RST_GROWTH_FACTOR    = 16'd512;
  localparam logic [7:0]  RST_FLOOR_SEGMENTS   = 8'd4;
  localparam logic [7:0]  RST_INITIAL_SEGMENTS = 8'd10;
  localparam logic [WIN_W-1:0] RST_WINDOW      = WIN_W'(15000);

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_START     = 5'd2;
  localparam logic [OP_W-1:0] OP_ACK_PRE   = 5'd3;
  localparam logic [OP_W-1:0] OP_NACK_PRE  = 5'd4;
  localparam logic [OP_W-1:0] OP_SS_ADD    = 5'd5;
  localparam logic [OP_W-1:0] OP_SQ        = 5'd6;
  localparam logic [OP_W-1:0] OP_GROW      = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV_AI    = 5'd8;
  localparam logic [OP_W-1:0] OP_DIV_FRAC  = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd10;
  localparam logic [OP_W-1:0] OP_AI_ADD    = 5'd11;
  localparam logic [OP_W-1:0] OP_FRAC      = 5'd12;
  localparam logic [OP_W-1:0] OP_ALPHA_P1  = 5'd13;
  localparam logic [OP_W-1:0] OP_ALPHA_P2  = 5'd14;
  localparam logic [OP_W-1:0] OP_ALPHA_SUM = 5'd15;
  localparam logic [OP_W-1:0] OP_CUT_LO    = 5'd16;
  localparam logic [OP_W-1:0] OP_CUT_HI    = 5'd17;
  localparam logic [OP_W-1:0] OP_CUT_SET   = 5'd18;
  localparam logic [OP_W-1:0] OP_DP        = 5'd19;
  localparam logic [OP_W-1:0] OP_SEND      = 5'd20;

  typedef struct packed {
    logic       started;
    logic [1:0] kind;
    logic       ack_ge_dp;
    logic       slow_start;
    logic       div_done;
    logic       can_send;
    logic       send_space;
  } dp_status_t;

endpackage

@@ design/dwc_dp.sv @@
// datapath: flow state, shared divider, multipliers and send register
module dwc_dp #(
  parameter int SEQ_BITS  = 48,
  parameter int MAX_BURST = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dwc_pkg::cfg_t                   cfg,
  input  dwc_pkg::in_item_t               in_data,
  input  logic [dwc_pkg::OP_W-1:0]        op,
  input  logic                            out_ready,
  output logic                            out_valid,
  output dwc_pkg::out_item_t              out_data,
  output dwc_pkg::dp_status_t             status,
  output logic                            last_send
);

  localparam int WW    = dwc_pkg::WIN_W;
  localparam int CW    = dwc_pkg::CNT_W;
  localparam int FW    = FRAC_BITS + 1;
  localparam int FCW   = FRAC_BITS + 2;
  localparam int HALF  = WW / 2;
  localparam int PW    = WW + FCW;
  localparam int DIV_W = (CW + FRAC_BITS > 48) ? CW + FRAC_BITS : 48;
  localparam int DCW   = $clog2(DIV_W + 1);
  localparam int BCW   = $clog2(MAX_BURST + 1);
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [47:0] MAX_INF = {48{1'b1}};
  localparam logic [WW-1:0] MAX_WIN = {WW{1'b1}};

  logic                 started_r;
  logic [1:0]           kind_r;
  logic [47:0]          ack_r;
  logic                 ecn_r;
  logic [WW-1:0]        window_r;
  logic [WW-1:0]        ssl_r;
  logic [FW-1:0]        alpha_r;
  logic [SEQ_BITS-1:0]  dp_r;
  logic [SEQ_BITS-1:0]  hs_r;
  logic [47:0]          inf_r;
  logic [CW-1:0]        acked_r;
  logic [CW-1:0]        marked_r;
  logic [23:0]          floor_r;
  logic [23:0]          init_r;
  logic [47:0]          prod_r;
  logic [FW-1:0]        frac_r;
  logic [2*FW-1:0]      ap1_r;
  logic [2*FW-1:0]      ap2_r;
  logic [PW-1:0]        acc_r;
  logic [WW-1:0]        rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [WW-1:0]        den_r;
  logic [DCW-1:0]       dcnt_r;
  logic [BCW-1:0]       bcnt_r;
  logic                 out_valid_r;
  dwc_pkg::out_item_t   out_data_r;

  logic [31:0]          one32;
  logic [FW-1:0]        g_c;
  logic [FW-1:0]        loss_c;
  logic [WW:0]          rem_sh;
  logic                 q_bit;
  logic [WW-1:0]        rem_nxt;
  logic [47:0]          inf_dec;
  logic [48:0]          inf_add;
  logic [47:0]          inf_sat;
  logic [WW:0]          send_sum;
  logic [WW:0]          send_sum2;
  logic                 cond_now;
  logic                 cond_next;
  logic                 last_flag;
  logic                 send_fire;
  logic [WW:0]          win_ss;
  logic [WW:0]          win_ai;
  logic [FCW-1:0]       cut_f;
  logic [HALF+FCW-1:0]  lo_p;
  logic [WW-HALF+FCW-1:0] hi_p;
  logic [WW-1:0]        nw;
  logic [WW-1:0]        fl;
  logic [WW-1:0]        nwin;
  logic [31:0]          sq;
  logic [2*FW:0]        asum;
  logic [SEQ_BITS-1:0]  hs_inc;

  assign one32  = 32'(ONE);
  assign g_c    = (32'(cfg.ewma_gain) > one32) ? ONE : FW'(cfg.ewma_gain);
  assign loss_c = (32'(cfg.loss_shrink) > one32) ? ONE : FW'(cfg.loss_shrink);

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign q_bit   = rem_sh >= {1'b0, den_r};
  assign rem_nxt = q_bit ? WW'(rem_sh - {1'b0, den_r}) : WW'(rem_sh);

  assign inf_dec = (inf_r > 48'(cfg.segment_size)) ? inf_r - 48'(cfg.segment_size) : 48'd0;
  assign inf_add = 49'(inf_r) + 49'(cfg.segment_size);
  assign inf_sat = inf_add[48] ? MAX_INF : inf_add[47:0];

  assign send_sum  = (WW+1)'(inf_r) + (WW+1)'(cfg.segment_size);
  assign send_sum2 = (WW+1)'(inf_sat) + (WW+1)'(cfg.segment_size);
  assign cond_now  = (send_sum < {1'b0, window_r}) && (32'(bcnt_r) < 32'(MAX_BURST));
  assign cond_next = (send_sum2 < {1'b0, window_r}) && (32'(bcnt_r) + 32'd1 < 32'(MAX_BURST));
  assign last_flag = !cond_next;
  assign send_fire = (op == dwc_pkg::OP_SEND) && cond_now && (!out_valid_r || out_ready);

  assign win_ss = (WW+1)'(window_r) + (WW+1)'(cfg.segment_size);
  assign win_ai = (WW+1)'(window_r) + (WW+1)'(quo_r >> 8);

  assign cut_f = (kind_r == dwc_pkg::KIND_NACK) ? FCW'(loss_c)
                                                 : (FCW'(ONE) << 1) - FCW'(alpha_r);
  assign lo_p  = window_r[HALF-1:0] * cut_f;
  assign hi_p  = window_r[WW-1:HALF] * cut_f;
  assign nw    = (kind_r == dwc_pkg::KIND_NACK) ? WW'(acc_r >> FRAC_BITS)
                                                 : WW'(acc_r >> (FRAC_BITS + 1));
  assign fl    = WW'(floor_r);
  assign nwin  = (nw > fl) ? nw : fl;

  assign sq     = cfg.segment_size * cfg.segment_size;
  assign asum   = (2*FW+1)'(ap1_r) + (2*FW+1)'(ap2_r);
  assign hs_inc = hs_r + SEQ_BITS'(1);

  always_ff @(posedge clk) begin
    floor_r <= cfg.floor_segments * cfg.segment_size;
    init_r  <= cfg.initial_segments * cfg.segment_size;
    if (!rst_n) begin
      started_r   <= 1'b0;
      window_r    <= dwc_pkg::RST_WINDOW;
      ssl_r       <= MAX_WIN;
      alpha_r     <= '0;
      dp_r        <= '0;
      hs_r        <= '0;
      inf_r       <= '0;
      acked_r     <= '0;
      marked_r    <= '0;
      dcnt_r      <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (send_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        dwc_pkg::OP_LOAD: begin
          kind_r <= in_data.kind;
          ack_r  <= in_data.ack_number;
          ecn_r  <= in_data.ecn_marked;
          bcnt_r <= '0;
        end
        dwc_pkg::OP_START: begin
          started_r <= 1'b1;
          hs_r      <= '0;
          window_r  <= WW'(init_r);
        end
        dwc_pkg::OP_ACK_PRE: begin
          inf_r   <= inf_dec;
          acked_r <= acked_r + CW'(1);
          if (ecn_r) begin
            marked_r <= marked_r + CW'(1);
          end
        end
        dwc_pkg::OP_NACK_PRE: begin
          inf_r <= inf_dec;
        end
        dwc_pkg::OP_SS_ADD: begin
          window_r <= win_ss[WW] ? MAX_WIN : win_ss[WW-1:0];
        end
        dwc_pkg::OP_SQ: begin
          prod_r <= 48'(sq);
        end
        dwc_pkg::OP_GROW: begin
          prod_r <= prod_r[31:0] * cfg.growth_factor;
        end
        dwc_pkg::OP_DIV_AI: begin
          quo_r  <= DIV_W'(prod_r);
          den_r  <= (window_r == '0) ? WW'(1) : window_r;
          rem_r  <= '0;
          dcnt_r <= DCW'(DIV_W);
        end
        dwc_pkg::OP_DIV_FRAC: begin
          quo_r  <= DIV_W'({marked_r, {FRAC_BITS{1'b0}}});
          den_r  <= WW'(acked_r);
          rem_r  <= '0;
          dcnt_r <= DCW'(DIV_W);
        end
        dwc_pkg::OP_DIV_STEP: begin
          quo_r  <= {quo_r[DIV_W-2:0], q_bit};
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r - DCW'(1);
        end
        dwc_pkg::OP_AI_ADD: begin
          window_r <= win_ai[WW] ? MAX_WIN : win_ai[WW-1:0];
        end
        dwc_pkg::OP_FRAC: begin
          if (acked_r == '0) begin
            frac_r <= '0;
          end else if (marked_r >= acked_r) begin
            frac_r <= ONE;
          end else begin
            frac_r <= quo_r[FW-1:0];
          end
        end
        dwc_pkg::OP_ALPHA_P1: begin
          ap1_r <= (ONE - g_c) * alpha_r;
        end
        dwc_pkg::OP_ALPHA_P2: begin
          ap2_r <= g_c * frac_r;
        end
        dwc_pkg::OP_ALPHA_SUM: begin
          alpha_r <= FW'(asum >> FRAC_BITS);
        end
        dwc_pkg::OP_CUT_LO: begin
          acc_r <= PW'(lo_p);
        end
        dwc_pkg::OP_CUT_HI: begin
          acc_r <= acc_r + (PW'(hi_p) << HALF);
        end
        dwc_pkg::OP_CUT_SET: begin
          window_r <= nwin;
          if (kind_r == dwc_pkg::KIND_NACK) begin
            ssl_r <= nwin;
          end else begin
            acked_r  <= '0;
            marked_r <= '0;
          end
        end
        dwc_pkg::OP_DP: begin
          dp_r <= hs_r + SEQ_BITS'(window_r);
        end
        dwc_pkg::OP_SEND: begin
          if (send_fire) begin
            out_data_r.send_seqno <= dwc_pkg::SEQ_OUT_W'(hs_inc);
            out_data_r.last       <= last_flag;
            hs_r                  <= hs_r + SEQ_BITS'(cfg.segment_size);
            inf_r                 <= inf_sat;
            bcnt_r                <= bcnt_r + BCW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign last_send         = last_flag;
  assign status.started    = started_r;
  assign status.kind       = kind_r;
  assign status.ack_ge_dp  = 64'(ack_r) >= 64'(dp_r);
  assign status.slow_start = window_r < ssl_r;
  assign status.div_done   = (dcnt_r == '0);
  assign status.can_send   = cond_now;
  assign status.send_space = !out_valid_r || out_ready;

endmodule

@@ design/dwc_ctrl.sv @@
// controller state machine that sequences the datapath for one event
module dwc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dwc_pkg::dp_status_t        status,
  input  logic                       last_send,
  output logic [dwc_pkg::OP_W-1:0]   op
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_ACK_BR  = 4'd2;
  localparam logic [3:0] S_NACK_BR = 4'd3;
  localparam logic [3:0] S_GROW    = 4'd4;
  localparam logic [3:0] S_AI_LOAD = 4'd5;
  localparam logic [3:0] S_DIV_AI  = 4'd6;
  localparam logic [3:0] S_DIV_FR  = 4'd7;
  localparam logic [3:0] S_ALPHA1  = 4'd8;
  localparam logic [3:0] S_ALPHA2  = 4'd9;
  localparam logic [3:0] S_ALPHA3  = 4'd10;
  localparam logic [3:0] S_CUT_LO  = 4'd11;
  localparam logic [3:0] S_CUT_HI  = 4'd12;
  localparam logic [3:0] S_CUT_SET = 4'd13;
  localparam logic [3:0] S_DP      = 4'd14;
  localparam logic [3:0] S_SEND    = 4'd15;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = dwc_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = dwc_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (status.kind == dwc_pkg::KIND_START) begin
          if (status.started) begin
            state_nxt = S_IDLE;
          end else begin
            op        = dwc_pkg::OP_START;
            state_nxt = S_SEND;
          end
        end else if (!status.started) begin
          state_nxt = S_IDLE;
        end else if (status.kind == dwc_pkg::KIND_ACK) begin
          op        = dwc_pkg::OP_ACK_PRE;
          state_nxt = S_ACK_BR;
        end else if (status.kind == dwc_pkg::KIND_NACK) begin
          op        = dwc_pkg::OP_NACK_PRE;
          state_nxt = S_NACK_BR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACK_BR: begin
        if (status.ack_ge_dp) begin
          op        = dwc_pkg::OP_DIV_FRAC;
          state_nxt = S_DIV_FR;
        end else if (status.slow_start) begin
          op        = dwc_pkg::OP_SS_ADD;
          state_nxt = S_SEND;
        end else begin
          op        = dwc_pkg::OP_SQ;
          state_nxt = S_GROW;
        end
      end
      S_NACK_BR: begin
        state_nxt = status.ack_ge_dp ? S_CUT_LO : S_SEND;
      end
      S_GROW: begin
        op        = dwc_pkg::OP_GROW;
        state_nxt = S_AI_LOAD;
      end
      S_AI_LOAD: begin
        op        = dwc_pkg::OP_DIV_AI;
        state_nxt = S_DIV_AI;
      end
      S_DIV_AI: begin
        if (status.div_done) begin
          op        = dwc_pkg::OP_AI_ADD;
          state_nxt = S_SEND;
        end else begin
          op = dwc_pkg::OP_DIV_STEP;
        end
      end
      S_DIV_FR: begin
        if (status.div_done) begin
          op        = dwc_pkg::OP_FRAC;
          state_nxt = S_ALPHA1;
        end else begin
          op = dwc_pkg::OP_DIV_STEP;
        end
      end
      S_ALPHA1: begin
        op        = dwc_pkg::OP_ALPHA_P1;
        state_nxt = S_ALPHA2;
      end
      S_ALPHA2: begin
        op        = dwc_pkg::OP_ALPHA_P2;
        state_nxt = S_ALPHA3;
      end
      S_ALPHA3: begin
        op        = dwc_pkg::OP_ALPHA_SUM;
        state_nxt = S_CUT_LO;
      end
      S_CUT_LO: begin
        op        = dwc_pkg::OP_CUT_LO;
        state_nxt = S_CUT_HI;
      end
      S_CUT_HI: begin
        op        = dwc_pkg::OP_CUT_HI;
        state_nxt = S_CUT_SET;
      end
      S_CUT_SET: begin
        op        = dwc_pkg::OP_CUT_SET;
        state_nxt = S_DP;
      end
      S_DP: begin
        op        = dwc_pkg::OP_DP;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        op = dwc_pkg::OP_SEND;
        if (!status.can_send) begin
          state_nxt = S_IDLE;
        end else if (status.send_space && last_send) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/dctcp_window_controller.sv @@
// top level: configuration registers, controller and datapath of the dctcp window controller
// One event at a time. An ignored event returns straight to idle; a start, a plain
// nack or a slow-start ack goes on to send; a window-cutting nack first cuts the
// window, a congestion-avoidance ack first runs the divider and a window-cut ack
// first runs the divider, the alpha update and the cut; output stalls lengthen the
// send. DIV_W = max(48, 32 + FRAC_BITS) (48 bits at the defaults) is the width of
// the one-bit-per-cycle restoring divider.
// Up to MAX_BURST segments leave per event, one per cycle while the output is
// taken; the next event is taken once the last segment sits in the output register.
module dctcp_window_controller #(
  parameter int SEQ_BITS  = 48,
  parameter int MAX_BURST = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dwc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dwc_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dwc_pkg::cfg_t                cfg_r;
  dwc_pkg::dp_status_t          status;
  logic [dwc_pkg::OP_W-1:0]     op;
  logic                         last_send;
  logic [2:0]                   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.segment_size     <= dwc_pkg::RST_SEGMENT_SIZE;
      cfg_r.ewma_gain        <= dwc_pkg::RST_EWMA_GAIN;
      cfg_r.loss_shrink      <= dwc_pkg::RST_LOSS_SHRINK;
      cfg_r.growth_factor    <= dwc_pkg::RST_GROWTH_FACTOR;
      cfg_r.floor_segments   <= dwc_pkg::RST_FLOOR_SEGMENTS;
      cfg_r.initial_segments <= dwc_pkg::RST_INITIAL_SEGMENTS;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        dwc_pkg::REG_SEGMENT_SIZE:     cfg_r.segment_size     <= pwdata[15:0];
        dwc_pkg::REG_EWMA_GAIN:        cfg_r.ewma_gain        <= pwdata[16:0];
        dwc_pkg::REG_LOSS_SHRINK:      cfg_r.loss_shrink      <= pwdata[16:0];
        dwc_pkg::REG_GROWTH_FACTOR:    cfg_r.growth_factor    <= pwdata[15:0];
        dwc_pkg::REG_FLOOR_SEGMENTS:   cfg_r.floor_segments   <= pwdata[7:0];
        dwc_pkg::REG_INITIAL_SEGMENTS: cfg_r.initial_segments <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dwc_pkg::REG_SEGMENT_SIZE:     prdata = 32'(cfg_r.segment_size);
      dwc_pkg::REG_EWMA_GAIN:        prdata = 32'(cfg_r.ewma_gain);
      dwc_pkg::REG_LOSS_SHRINK:      prdata = 32'(cfg_r.loss_shrink);
      dwc_pkg::REG_GROWTH_FACTOR:    prdata = 32'(cfg_r.growth_factor);
      dwc_pkg::REG_FLOOR_SEGMENTS:   prdata = 32'(cfg_r.floor_segments);
      dwc_pkg::REG_INITIAL_SEGMENTS: prdata = 32'(cfg_r.initial_segments);
      default:                       prdata = 32'd0;
    endcase
  end

  dwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .status    (status),
    .last_send (last_send),
    .op        (op)
  );

  dwc_dp #(
    .SEQ_BITS  (SEQ_BITS),
    .MAX_BURST (MAX_BURST),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .op        (op),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status),
    .last_send (last_send)
  );

endmodule
